>>> design/rts_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the key select function of the ready task selector.
// No dependencies.

package rts_pkg;

  localparam int KEY_W      = 16;
  localparam int POLICY_W   = 3;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int OUT_IDX_W  = 4;
  localparam int IN_IDX_W   = 4;

  localparam logic [POLICY_W-1:0] POL_FCFS = 3'd0;
  localparam logic [POLICY_W-1:0] POL_SJF  = 3'd1;
  localparam logic [POLICY_W-1:0] POL_PRIO = 3'd2;
  localparam logic [POLICY_W-1:0] POL_RM   = 3'd3;
  localparam logic [POLICY_W-1:0] POL_EDF  = 3'd4;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_PICK  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd1;

  typedef struct packed {
    logic [KEY_W-1:0] arrival;
    logic [KEY_W-1:0] remaining;
    logic [KEY_W-1:0] prio;
    logic [KEY_W-1:0] period;
    logic [KEY_W-1:0] deadline;
  } entry_t;

  typedef struct packed {
    logic   en;
    logic   ready;
    entry_t entry;
  } tbl_wr_t;

  function automatic logic [KEY_W-1:0] key_sel(input logic [POLICY_W-1:0] policy,
                                               input entry_t entry);
    logic [KEY_W-1:0] key;
    case (policy)
      POL_SJF:  key = entry.remaining;
      POL_PRIO: key = entry.prio;
      POL_RM:   key = entry.period;
      POL_EDF:  key = entry.deadline;
      default:  key = entry.arrival;
    endcase
    return key;
  endfunction

endpackage

>>> design/rts_table.sv
`timescale 1ns / 1ps
// Task table: entry memory with one write and one registered read port,
// plus per-entry ready flags. Depends on rts_pkg.

module rts_table #(
  parameter int MAX_ENTRIES = 16,
  localparam int IDX_W = $clog2(MAX_ENTRIES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rts_pkg::tbl_wr_t    wr,
  input  logic [IDX_W-1:0]    wr_addr,
  input  logic [IDX_W-1:0]    rd_addr,
  output logic                rd_ready,
  output rts_pkg::entry_t     rd_entry
);

  rts_pkg::entry_t        mem_r [MAX_ENTRIES];
  rts_pkg::entry_t        rd_entry_r;
  logic                   rd_ready_r;
  logic [MAX_ENTRIES-1:0] rdy_r;
  logic [MAX_ENTRIES-1:0] rdy_nxt;

  always_comb begin
    rdy_nxt = rdy_r;
    if (wr.en) begin
      rdy_nxt[wr_addr] = wr.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdy_r <= '0;
    end else begin
      rdy_r <= rdy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr_addr] <= wr.entry;
    end
    rd_entry_r <= mem_r[rd_addr];
    rd_ready_r <= rdy_r[rd_addr];
  end

  assign rd_entry = rd_entry_r;
  assign rd_ready = rd_ready_r;

endmodule

>>> design/rts_scan.sv
`timescale 1ns / 1ps
// Pick sequencer: walks the table one entry per cycle through a single
// key compare unit and strobes the result. Depends on rts_pkg.

module rts_scan #(
  parameter int MAX_ENTRIES = 16,
  localparam int IDX_W = $clog2(MAX_ENTRIES),
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               func,
  input  logic [rts_pkg::POLICY_W-1:0]       policy,
  input  logic [rts_pkg::COUNT_W-1:0]        active_count,
  output logic                               busy,
  output logic [IDX_W-1:0]                   rd_addr,
  input  logic                               rd_ready,
  input  rts_pkg::entry_t                    rd_entry,
  output logic                               out_valid,
  output logic                               out_found,
  output logic [rts_pkg::OUT_IDX_W-1:0]      out_chosen_index
);

  localparam int LIM_W = (CNT_W > rts_pkg::COUNT_W) ? CNT_W : rts_pkg::COUNT_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [CNT_W-1:0]            lim_r, lim_nxt;
  logic                        found_r, found_nxt;
  logic [IDX_W-1:0]            best_idx_r, best_idx_nxt;
  logic [rts_pkg::KEY_W-1:0]   best_key_r, best_key_nxt;
  logic                        cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]            cmp_idx_r, cmp_idx_nxt;
  logic [rts_pkg::KEY_W-1:0]   key;
  logic [LIM_W-1:0]            ac_ext;
  logic [LIM_W-1:0]            max_ext;
  logic [CNT_W-1:0]            limit;

  assign ac_ext  = LIM_W'(active_count);
  assign max_ext = LIM_W'(MAX_ENTRIES);
  assign limit   = (ac_ext > max_ext) ? CNT_W'(max_ext) : CNT_W'(ac_ext);
  assign key     = rts_pkg::key_sel(policy, rd_entry);
  assign rd_addr = cnt_r[IDX_W-1:0];

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    lim_nxt      = lim_r;
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_key_nxt = best_key_r;
    cmp_vld_nxt  = (state_r == ST_SCAN);
    cmp_idx_nxt  = rd_addr;
    case (state_r)
      ST_IDLE: begin
        if (start && func == rts_pkg::FUNC_PICK) begin
          cnt_nxt      = '0;
          lim_nxt      = limit;
          found_nxt    = 1'b0;
          best_idx_nxt = '0;
          state_nxt    = (limit == '0) ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == lim_r - CNT_W'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_FIN;
      ST_FIN:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
    if (cmp_vld_r && rd_ready && (!found_r || key < best_key_r)) begin
      found_nxt    = 1'b1;
      best_idx_nxt = cmp_idx_r;
      best_key_nxt = key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      found_r   <= 1'b0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      found_r   <= found_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lim_r      <= lim_nxt;
    best_idx_r <= best_idx_nxt;
    best_key_r <= best_key_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = (state_r == ST_FIN);
  assign out_found        = found_r;
  assign out_chosen_index = rts_pkg::OUT_IDX_W'(best_idx_r);

  a_pick_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && func == rts_pkg::FUNC_PICK) |=> busy)
    else $error("pick transfer did not start a scan");

  a_cmp_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> ($past(state_r) == ST_SCAN))
    else $error("compare stage loaded outside scan");

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_chosen_index == '0))
    else $error("empty pick returned nonzero index");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (cnt_r < lim_r))
    else $error("scan address past limit");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held more than one cycle");

endmodule

>>> design/ready_task_selector_top.sv
`timescale 1ns / 1ps
// Ready task selector top: configuration registers, write decode, task
// table and pick sequencer. Depends on rts_pkg, rts_table, rts_scan.
//
//   channel  handshake               transfer when           payload
//   input    start / busy            start && !busy          in_func .. in_deadline_time
//   result   out_valid (strobe)      out_valid               out_found, out_chosen_index
//   config   cfg_valid / cfg_ready   cfg_valid && cfg_ready  cfg_index, cfg_data
//
// A write item stores its entry at the transfer edge; busy stays low.
// A pick holds busy while it reads min(active_count, MAX_ENTRIES) table entries,
// one per cycle through the single read port, then a drain state for the last compare
// and a final state in which out_valid strobes the result; a zero count goes straight there.
// Reset (rst_n low, synchronous) clears the ready flags and both registers.
// Results cannot be stalled; cfg_ready is always high.

module ready_task_selector_top #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_func,
  input  logic [rts_pkg::IN_IDX_W-1:0]        in_entry_index,
  input  logic                                in_ready_req,
  input  logic [rts_pkg::KEY_W-1:0]           in_arrival_time,
  input  logic [rts_pkg::KEY_W-1:0]           in_remaining_time,
  input  logic [rts_pkg::KEY_W-1:0]           in_priority_value,
  input  logic [rts_pkg::KEY_W-1:0]           in_period_length,
  input  logic [rts_pkg::KEY_W-1:0]           in_deadline_time,
  output logic                                out_valid,
  output logic                                out_found,
  output logic [rts_pkg::OUT_IDX_W-1:0]       out_chosen_index,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rts_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int EI_W  = ((IDX_W > rts_pkg::IN_IDX_W) ? IDX_W : rts_pkg::IN_IDX_W) + 1;

  logic [rts_pkg::POLICY_W-1:0] policy_r, policy_nxt;
  logic [rts_pkg::COUNT_W-1:0]  count_r, count_nxt;
  rts_pkg::tbl_wr_t             wr;
  logic [IDX_W-1:0]             wr_addr;
  logic [IDX_W-1:0]             rd_addr;
  logic                         rd_ready;
  rts_pkg::entry_t              rd_entry;
  logic                         in_range;

  assign cfg_ready = 1'b1;

  always_comb begin
    policy_nxt = policy_r;
    count_nxt  = count_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rts_pkg::CFG_POLICY: policy_nxt = cfg_data[rts_pkg::POLICY_W-1:0];
        rts_pkg::CFG_COUNT:  count_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= rts_pkg::POL_FCFS;
      count_r  <= '0;
    end else begin
      policy_r <= policy_nxt;
      count_r  <= count_nxt;
    end
  end

  assign in_range = (EI_W'(in_entry_index) < EI_W'(MAX_ENTRIES));
  assign wr_addr  = IDX_W'(in_entry_index);

  always_comb begin
    wr.en             = start && !busy && in_func == rts_pkg::FUNC_WRITE && in_range;
    wr.ready          = in_ready_req;
    wr.entry.arrival   = in_arrival_time;
    wr.entry.remaining = in_remaining_time;
    wr.entry.prio      = in_priority_value;
    wr.entry.period    = in_period_length;
    wr.entry.deadline  = in_deadline_time;
  end

  rts_table #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .rd_ready (rd_ready),
    .rd_entry (rd_entry)
  );

  rts_scan #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_scan (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .func             (in_func),
    .policy           (policy_r),
    .active_count     (count_r),
    .busy             (busy),
    .rd_addr          (rd_addr),
    .rd_ready         (rd_ready),
    .rd_entry         (rd_entry),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_chosen_index (out_chosen_index)
  );

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Testbench for ready_task_selector_top: a queue-fed driver, a result monitor and
// an in-bench task table that predicts every pick. Depends on rts_pkg and the design.

module tb;

  localparam int TBL_DEPTH     = 16;
  localparam int SETTLE_CYCLES = 2 * TBL_DEPTH + 8;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int RAND_PHASES   = 13;
  localparam int PHASE_ITEMS   = 104;

  localparam logic [rts_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [rts_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct {
    logic                         func;
    logic [rts_pkg::IN_IDX_W-1:0] idx;
    logic                         rdy;
    rts_pkg::entry_t              ent;
    bit                           wait_empty;
  } task_req_t;

  typedef struct packed {
    logic                          found;
    logic [rts_pkg::OUT_IDX_W-1:0] idx;
  } pick_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  logic                           in_func = rts_pkg::FUNC_WRITE;
  logic [rts_pkg::IN_IDX_W-1:0]   in_entry_index = '0;
  logic                           in_ready_req = 1'b0;
  logic [rts_pkg::KEY_W-1:0]      in_arrival_time = '0;
  logic [rts_pkg::KEY_W-1:0]      in_remaining_time = '0;
  logic [rts_pkg::KEY_W-1:0]      in_priority_value = '0;
  logic [rts_pkg::KEY_W-1:0]      in_period_length = '0;
  logic [rts_pkg::KEY_W-1:0]      in_deadline_time = '0;
  logic                           out_valid;
  logic                           out_found;
  logic [rts_pkg::OUT_IDX_W-1:0]  out_chosen_index;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [rts_pkg::CFG_IDX_W-1:0]  cfg_index = rts_pkg::CFG_POLICY;
  logic [rts_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // task table and registers as the block should hold them
  logic                         ready_tbl [TBL_DEPTH] = '{default: 1'b0};
  rts_pkg::entry_t              task_tbl [TBL_DEPTH];
  logic [rts_pkg::POLICY_W-1:0] sel_policy = rts_pkg::POL_FCFS;
  logic [rts_pkg::COUNT_W-1:0]  scan_count = '0;

  task_req_t pending_q [$];
  pick_t     pick_q [$];
  task_req_t cur_req;
  int        gap_left = 0;
  int        gap_pct = 0;
  int        errors = 0;
  int        cycle_cnt = 0;

  ready_task_selector_top #(.MAX_ENTRIES(TBL_DEPTH)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_entry_index   (in_entry_index),
    .in_ready_req     (in_ready_req),
    .in_arrival_time  (in_arrival_time),
    .in_remaining_time(in_remaining_time),
    .in_priority_value(in_priority_value),
    .in_period_length (in_period_length),
    .in_deadline_time (in_deadline_time),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_chosen_index (out_chosen_index),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic pick_t choose_task();
    pick_t                     res;
    logic [rts_pkg::KEY_W-1:0] best_key;
    logic [rts_pkg::KEY_W-1:0] k;
    int                        lim;
    res = '0;
    best_key = '0;
    lim = (scan_count > TBL_DEPTH) ? TBL_DEPTH : int'(scan_count);
    for (int i = 0; i < lim; i++) begin
      if (ready_tbl[i]) begin
        case (sel_policy)
          rts_pkg::POL_SJF:  k = task_tbl[i].remaining;
          rts_pkg::POL_PRIO: k = task_tbl[i].prio;
          rts_pkg::POL_RM:   k = task_tbl[i].period;
          rts_pkg::POL_EDF:  k = task_tbl[i].deadline;
          default:           k = task_tbl[i].arrival;
        endcase
        if (!res.found || k < best_key) begin
          res.found = 1'b1;
          res.idx = rts_pkg::OUT_IDX_W'(i);
          best_key = k;
        end
      end
    end
    return res;
  endfunction

  function automatic logic [rts_pkg::KEY_W-1:0] rand_key(bit narrow);
    return narrow ? rts_pkg::KEY_W'($urandom_range(0, 3)) : rts_pkg::KEY_W'($urandom);
  endfunction

  task automatic push_write(input int idx, input logic rdy, input rts_pkg::entry_t ent);
    task_req_t r;
    r.func = rts_pkg::FUNC_WRITE;
    r.idx = rts_pkg::IN_IDX_W'(idx);
    r.rdy = rdy;
    r.ent = ent;
    r.wait_empty = 1'b0;
    pending_q.push_back(r);
  endtask

  task automatic push_random(input bit force_wait);
    task_req_t r;
    bit        narrow;
    narrow = 1'($urandom_range(1));
    r.func = ($urandom_range(99) < 40) ? rts_pkg::FUNC_PICK : rts_pkg::FUNC_WRITE;
    r.idx = rts_pkg::IN_IDX_W'($urandom);
    r.rdy = ($urandom_range(3) != 0);
    r.ent.arrival = rand_key(narrow);
    r.ent.remaining = rand_key(narrow);
    r.ent.prio = rand_key(narrow);
    r.ent.period = rand_key(narrow);
    r.ent.deadline = rand_key(narrow);
    r.wait_empty = force_wait || (gap_pct > 0 && $urandom_range(59) == 0);
    pending_q.push_back(r);
  endtask

  task automatic push_pick();
    task_req_t r;
    r.func = rts_pkg::FUNC_PICK;
    r.idx = rts_pkg::IN_IDX_W'($urandom);
    r.rdy = 1'($urandom_range(1));
    r.ent.arrival = rand_key(1'b0);
    r.ent.remaining = rand_key(1'b0);
    r.ent.prio = rand_key(1'b0);
    r.ent.period = rand_key(1'b0);
    r.ent.deadline = rand_key(1'b0);
    r.wait_empty = 1'b0;
    pending_q.push_back(r);
  endtask

  task automatic write_reg(input logic [rts_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rts_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rts_pkg::CFG_POLICY: sel_policy = val[rts_pkg::POLICY_W-1:0];
      rts_pkg::CFG_COUNT:  scan_count = val[rts_pkg::COUNT_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    do @(negedge clk); while (pending_q.size() != 0 || start || busy || pick_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // driver: present queued items, hold each until the transfer
  always @(posedge clk) begin : drive_proc
    logic start_nx;
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      start_nx = start;
      if (start && !busy) begin
        if (cur_req.func == rts_pkg::FUNC_PICK) begin
          pick_q.push_back(choose_task());
        end else begin
          ready_tbl[cur_req.idx] = cur_req.rdy;
          task_tbl[cur_req.idx] = cur_req.ent;
        end
        start_nx = 1'b0;
      end
      if (!start_nx && pending_q.size() != 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q[0].wait_empty && (pick_q.size() != 0 || busy)) begin
          gap_left = 0;
        end else if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
          gap_left = $urandom_range(0, 10);
        end else begin
          cur_req = pending_q.pop_front();
          in_func <= cur_req.func;
          in_entry_index <= cur_req.idx;
          in_ready_req <= cur_req.rdy;
          in_arrival_time <= cur_req.ent.arrival;
          in_remaining_time <= cur_req.ent.remaining;
          in_priority_value <= cur_req.ent.prio;
          in_period_length <= cur_req.ent.period;
          in_deadline_time <= cur_req.ent.deadline;
          start_nx = 1'b1;
        end
      end
      start <= start_nx;
    end
  end

  // monitor: compare each strobed result with the oldest predicted pick
  always @(posedge clk) begin : check_proc
    pick_t exp_pick;
    if (rst_n && out_valid) begin
      if (pick_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got found=%0b index=%0d",
                 $time, out_found, out_chosen_index);
        errors++;
      end else begin
        exp_pick = pick_q.pop_front();
        if (out_found !== exp_pick.found) begin
          $display("%0t: found mismatch, expected %0b, got %0b",
                   $time, exp_pick.found, out_found);
          errors++;
        end
        if (out_chosen_index !== exp_pick.idx) begin
          $display("%0t: chosen_index mismatch, expected %0d, got %0d",
                   $time, exp_pick.idx, out_chosen_index);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stim_proc
    rts_pkg::entry_t              ent;
    logic                         rdy;
    logic [rts_pkg::KEY_W-1:0]    fill;
    int unsigned                  phase_counts [8];
    logic [rts_pkg::POLICY_W-1:0] pol;
    logic [rts_pkg::COUNT_W-1:0]  cnt;

    phase_counts = '{16, 0, 31, 1, 17, 16, 2, 8};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // pick with an empty scan right after reset, then load every entry
    push_pick();
    for (int i = 0; i < TBL_DEPTH; i++) begin
      fill = (i % 2 == 0) ? 16'h5555 : 16'hAAAA;
      ent = {5{fill}};
      rdy = 1'b1;
      if (i <= 5) ent = {5{16'hFFFF}};
      case (i)
        1: ent.arrival = '0;
        2: ent.remaining = '0;
        3: ent.prio = '0;
        4: ent.period = '0;
        5: ent.deadline = '0;
        6: ent = {16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h0001};
        7: begin
          ent = '0;
          rdy = 1'b0;
        end
        15: ent = '0;
        default: ;
      endcase
      push_write(i, rdy, ent);
    end
    settle();

    // one pick per policy code, unused codes included
    write_reg(rts_pkg::CFG_COUNT, rts_pkg::CFG_DATA_W'(TBL_DEPTH));
    for (int p = 0; p < 8; p++) begin
      write_reg(rts_pkg::CFG_POLICY, {2'($urandom), rts_pkg::POLICY_W'(p)});
      push_pick();
      settle();
    end

    // oversized count, writes to unlisted register indexes, single-entry scan
    write_reg(rts_pkg::CFG_POLICY, rts_pkg::CFG_DATA_W'(rts_pkg::POL_EDF));
    write_reg(rts_pkg::CFG_COUNT, '1);
    write_reg(CFG_SPARE_A, 5'd1);
    write_reg(CFG_SPARE_B, '0);
    push_pick();
    settle();
    write_reg(rts_pkg::CFG_COUNT, 5'd1);
    push_pick();
    settle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p < 8) begin
        pol = rts_pkg::POLICY_W'(p);
        cnt = rts_pkg::COUNT_W'(phase_counts[p]);
      end else begin
        pol = rts_pkg::POLICY_W'($urandom_range(0, 7));
        cnt = ($urandom_range(3) == 0) ? rts_pkg::COUNT_W'($urandom_range(17, 31))
                                       : rts_pkg::COUNT_W'($urandom_range(0, TBL_DEPTH));
      end
      write_reg(rts_pkg::CFG_POLICY, {2'($urandom), pol});
      write_reg(rts_pkg::CFG_COUNT, cnt);
      gap_pct = (p == RAND_PHASES - 1) ? 0 : (p % 3) * 20;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        push_random(k == PHASE_ITEMS / 2 && p != RAND_PHASES - 1);
      end
      settle();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
